FILE: src/e2x_pkg.sv
// Package for the edge-directed 2x scaler: pixel types, register map and
// the fixed-point constants of the distance and blend arithmetic.
// No dependencies; every other source file imports it.
package e2x_pkg;

   localparam int PIX_W           = 32;
   localparam int BYTE_W          = 8;
   localparam int BYTES_PER_WORD  = PIX_W / BYTE_W;
   localparam int MAX_PIXEL_BYTES = 4;

   // Pipeline depth of the scaler, in register stages.
   localparam int PIPE_STAGES = 5;

   // Configuration port.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_PIXEL_BYTES_ADDR = 2'd0;
   localparam logic [2:0]            PIXEL_BYTES_RESET    = 3'd4;

   // Two pixels are alike below this distance.
   localparam logic [8:0] ALIKE_LIMIT = 9'd40;

   // Blend weight is BLEND_BASE - BLEND_SLOPE * d, in units of 1/800.
   localparam logic [9:0] BLEND_BASE  = 10'd720;
   localparam logic [9:0] BLEND_SLOPE = 10'd11;

   // Unsigned x / 1000 for x < 2^18 as (x * DIV1000_MUL) >> DIV1000_SHIFT.
   localparam logic [18:0] DIV1000_MUL   = 19'd268436;
   localparam int          DIV1000_SHIFT = 28;
   // Unsigned x / 25 for x < 2^13 as (x * DIV25_MUL) >> DIV25_SHIFT.
   localparam logic [13:0] DIV25_MUL     = 14'd10486;
   localparam int          DIV25_SHIFT   = 18;

   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [2:0]        nbytes_type;

   // Colour-space terms of one pixel pair, before the division by 1000.
   typedef struct packed {
      logic [17:0] y_abs;
      logic [17:0] u_abs;
      logic [17:0] v_abs;
      byte_type    a_diff;
      byte_type    b0_diff;
      byte_type    b1_diff;
   } dterm_type;

   // The same terms after the division.
   typedef struct packed {
      logic [7:0] y_q;
      logic [7:0] u_q;
      logic [7:0] v_q;
      byte_type   a_diff;
      byte_type   b0_diff;
      byte_type   b1_diff;
   } dquot_type;

endpackage

FILE: src/e2x_req_if.sv
// Input channel of the scaler: valid/ready handshake carrying a centre pixel
// and its edge neighbours above, left, right and below. Depends on e2x_pkg.
interface e2x_req_if import e2x_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type centre_pixel;
   pixel_type above_pixel;
   pixel_type left_pixel;
   pixel_type right_pixel;
   pixel_type below_pixel;

   modport source (
      output valid, centre_pixel, above_pixel, left_pixel, right_pixel, below_pixel,
      input  ready
   );
   modport sink (
      input  valid, centre_pixel, above_pixel, left_pixel, right_pixel, below_pixel,
      output ready
   );
endinterface

FILE: src/e2x_rsp_if.sv
// Result channel of the scaler: valid/ready handshake carrying the 2x2 block
// of output pixels. Depends on e2x_pkg.
interface e2x_rsp_if import e2x_pkg::*; ();
   logic      valid;
   logic      ready;
   pixel_type upper_left_out;
   pixel_type upper_right_out;
   pixel_type lower_left_out;
   pixel_type lower_right_out;

   modport source (
      output valid, upper_left_out, upper_right_out, lower_left_out, lower_right_out,
      input  ready
   );
   modport sink (
      input  valid, upper_left_out, upper_right_out, lower_left_out, lower_right_out,
      output ready
   );
endinterface

FILE: src/edge_directed_2x_scaler.sv
// Top level of the edge-directed 2x scaler: five-stage pipeline plus the
// pixel_bytes register. Depends on e2x_pkg, e2x_req_if and e2x_rsp_if.
//
//   Channel   Direction  Handshake                      Beat contents
//   req_bus   in         valid/ready                    centre pixel and four neighbours
//   rsp_bus   out        valid/ready                    four output pixels (2x2 block)
//   csr (APB) in/out     psel, penable, pwrite, pready  pixel_bytes at byte address 0
//
// One beat can enter on every clock unless the pipeline is full and stalled. The beat
// lands in the first of the five register stages at the edge that takes it and moves
// on by one stage per edge, unless a stall holds it, until the last offers its result.
// Reset is synchronous and active high: it empties the pipeline and sets
// pixel_bytes to 4.
// Each stage carries its own valid bit and holds while the stage after it is
// full and stalled, so empty stages close up behind a stalled result and
// input beats keep being taken until the whole pipeline is full.
module edge_directed_2x_scaler import e2x_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   e2x_req_if.sink               req_bus,
   e2x_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NUM_PAIRS   = 6;
   localparam int NUM_CORNERS = 4;

   // ------------------------------------------------------------------
   // Configuration register. The user must write it only while the pipeline
   // is empty, which the block does not enforce; its clamped value is sampled as a beat enters.
   // ------------------------------------------------------------------
   logic [2:0] pixel_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff <= PIXEL_BYTES_RESET;
      end else if (psel && penable && pwrite && (paddr == REG_PIXEL_BYTES_ADDR)) begin
         pixel_bytes_ff <= pwdata[2:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == REG_PIXEL_BYTES_ADDR) ?
                   {{(CSR_DATA_W-3){1'b0}}, pixel_bytes_ff} : '0;

   // ------------------------------------------------------------------
   // Arithmetic helpers.
   // ------------------------------------------------------------------
   function automatic byte_type abs_diff8(byte_type x, byte_type y);
      return (x > y) ? byte_type'(x - y) : byte_type'(y - x);
   endfunction

   function automatic byte_type max8(byte_type x, byte_type y);
      return (x > y) ? x : y;
   endfunction

   // Signed colour differences weighted into luma and the two chroma terms,
   // returned as magnitudes. The magnitude of a quotient truncated toward
   // zero is the floor of the magnitude's quotient, so the sign goes here.
   function automatic dterm_type pair_terms(pixel_type p, pixel_type q);
      logic signed [18:0] r;
      logic signed [18:0] g;
      logic signed [18:0] b;
      logic signed [18:0] ys;
      logic signed [18:0] us;
      logic signed [18:0] vs;
      logic signed [18:0] ya;
      logic signed [18:0] ua;
      logic signed [18:0] va;
      dterm_type          t;
      r  = $signed({11'd0, p[7:0]})   - $signed({11'd0, q[7:0]});
      g  = $signed({11'd0, p[15:8]})  - $signed({11'd0, q[15:8]});
      b  = $signed({11'd0, p[23:16]}) - $signed({11'd0, q[23:16]});
      ys = r * 19'sd299 + g * 19'sd587 + b * 19'sd114;
      us = b * 19'sd500 - r * 19'sd169 - g * 19'sd331;
      vs = r * 19'sd500 - g * 19'sd419 - b * 19'sd81;
      ya = ys[18] ? -ys : ys;
      ua = us[18] ? -us : us;
      va = vs[18] ? -vs : vs;
      t.y_abs   = ya[17:0];
      t.u_abs   = ua[17:0];
      t.v_abs   = va[17:0];
      t.a_diff  = abs_diff8(p[31:24], q[31:24]);
      t.b0_diff = abs_diff8(p[7:0], q[7:0]);
      t.b1_diff = abs_diff8(p[15:8], q[15:8]);
      return t;
   endfunction

   function automatic pixel_type midpoint(pixel_type p, pixel_type q);
      logic [8:0] s;
      pixel_type  m;
      m = '0;
      for (int i = 0; i < BYTES_PER_WORD; i++) begin
         s = {1'b0, p[i*BYTE_W +: BYTE_W]} + {1'b0, q[i*BYTE_W +: BYTE_W]} + 9'd1;
         m[i*BYTE_W +: BYTE_W] = s[8:1];
      end
      return m;
   endfunction

   function automatic logic [36:0] mul_div1000(logic [17:0] x);
      return 37'(x) * 37'(DIV1000_MUL);
   endfunction

   // ------------------------------------------------------------------
   // Handshake: a stage loads when it is empty or the stage after it loads.
   // ------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   logic a_load, b_load, c_load, d_load, rsp_load;

   assign rsp_load = !rsp_valid_ff || rsp_bus.ready;
   assign d_load   = !d_valid_ff || rsp_load;
   assign c_load   = !c_valid_ff || d_load;
   assign b_load   = !b_valid_ff || c_load;
   assign a_load   = !a_valid_ff || b_load;

   assign req_bus.ready = a_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_load)   a_valid_ff   <= req_bus.valid;
         if (b_load)   b_valid_ff   <= a_valid_ff;
         if (c_load)   c_valid_ff   <= b_valid_ff;
         if (d_load)   d_valid_ff   <= c_valid_ff;
         if (rsp_load) rsp_valid_ff <= d_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage A: colour differences weighted by the luma/chroma constants for
   // all six pixel pairs, and the rounded midpoints of the corner pairs.
   // Pairs 0 and 1 are above/below and left/right and decide whether any
   // blending happens; pairs 2 to 5 belong to the corners in output order.
   // ------------------------------------------------------------------
   pixel_type  pair_p [NUM_PAIRS];
   pixel_type  pair_q [NUM_PAIRS];
   dterm_type  a_terms_in [NUM_PAIRS];
   pixel_type  a_mid_in [NUM_CORNERS];
   nbytes_type a_nbytes_in;

   dterm_type  a_terms_ff [NUM_PAIRS];
   pixel_type  a_mid_ff [NUM_CORNERS];
   pixel_type  a_centre_ff;
   nbytes_type a_nbytes_ff;

   always_comb begin
      pair_p[0] = req_bus.above_pixel;  pair_q[0] = req_bus.below_pixel;
      pair_p[1] = req_bus.left_pixel;   pair_q[1] = req_bus.right_pixel;
      pair_p[2] = req_bus.left_pixel;   pair_q[2] = req_bus.above_pixel;
      pair_p[3] = req_bus.above_pixel;  pair_q[3] = req_bus.right_pixel;
      pair_p[4] = req_bus.left_pixel;   pair_q[4] = req_bus.below_pixel;
      pair_p[5] = req_bus.below_pixel;  pair_q[5] = req_bus.right_pixel;
      for (int k = 0; k < NUM_PAIRS; k++) begin
         a_terms_in[k] = pair_terms(pair_p[k], pair_q[k]);
      end
      for (int k = 0; k < NUM_CORNERS; k++) begin
         a_mid_in[k] = midpoint(pair_p[k+2], pair_q[k+2]);
      end
      // Zero behaves as one byte, anything above the maximum as the maximum.
      if (pixel_bytes_ff == 3'd0) begin
         a_nbytes_in = nbytes_type'(1);
      end else if (32'(pixel_bytes_ff) > MAX_PIXEL_BYTES) begin
         a_nbytes_in = nbytes_type'(MAX_PIXEL_BYTES);
      end else begin
         a_nbytes_in = pixel_bytes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_terms_ff  <= a_terms_in;
         a_mid_ff    <= a_mid_in;
         a_centre_ff <= req_bus.centre_pixel;
         a_nbytes_ff <= a_nbytes_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: divide the three colour terms by 1000 through a reciprocal
   // multiplication, which is exact over their whole range.
   // ------------------------------------------------------------------
   dquot_type  b_quot_in [NUM_PAIRS];
   dquot_type  b_quot_ff [NUM_PAIRS];
   pixel_type  b_mid_ff [NUM_CORNERS];
   pixel_type  b_centre_ff;
   nbytes_type b_nbytes_ff;
   logic [36:0] y_prod [NUM_PAIRS];
   logic [36:0] u_prod [NUM_PAIRS];
   logic [36:0] v_prod [NUM_PAIRS];

   always_comb begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
         y_prod[k] = mul_div1000(a_terms_ff[k].y_abs);
         u_prod[k] = mul_div1000(a_terms_ff[k].u_abs);
         v_prod[k] = mul_div1000(a_terms_ff[k].v_abs);
         b_quot_in[k].y_q     = y_prod[k][DIV1000_SHIFT +: 8];
         b_quot_in[k].u_q     = u_prod[k][DIV1000_SHIFT +: 8];
         b_quot_in[k].v_q     = v_prod[k][DIV1000_SHIFT +: 8];
         b_quot_in[k].a_diff  = a_terms_ff[k].a_diff;
         b_quot_in[k].b0_diff = a_terms_ff[k].b0_diff;
         b_quot_in[k].b1_diff = a_terms_ff[k].b1_diff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_quot_ff   <= b_quot_in;
         b_mid_ff    <= a_mid_ff;
         b_centre_ff <= a_centre_ff;
         b_nbytes_ff <= a_nbytes_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage C: the distance of each pair for the number of bytes in use,
   // the likeness tests, and the blend weight of each corner.
   // ------------------------------------------------------------------
   logic [8:0] pair_dist [NUM_PAIRS];
   logic [8:0] dist3 [NUM_PAIRS];
   logic [NUM_PAIRS-1:0] alike;
   logic [NUM_CORNERS-1:0] c_blend_in;
   logic [9:0] c_weight_in [NUM_CORNERS];

   logic [NUM_CORNERS-1:0] c_blend_ff;
   logic [9:0]  c_weight_ff [NUM_CORNERS];
   pixel_type   c_mid_ff [NUM_CORNERS];
   pixel_type   c_centre_ff;
   nbytes_type  c_nbytes_ff;

   always_comb begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
         dist3[k] = 9'(b_quot_ff[k].y_q) + 9'(b_quot_ff[k].u_q[7:1])
                  + 9'(b_quot_ff[k].v_q[7:1]);
         if (b_nbytes_ff == 3'd1) begin
            pair_dist[k] = 9'(b_quot_ff[k].b0_diff);
         end else if (b_nbytes_ff == 3'd2) begin
            pair_dist[k] = 9'(max8(b_quot_ff[k].b0_diff, b_quot_ff[k].b1_diff));
         end else if (b_nbytes_ff == 3'd3) begin
            pair_dist[k] = dist3[k];
         end else begin
            pair_dist[k] = (dist3[k] > 9'(b_quot_ff[k].a_diff)) ?
                           dist3[k] : 9'(b_quot_ff[k].a_diff);
         end
         alike[k] = pair_dist[k] < ALIKE_LIMIT;
      end
      // A corner blends only when both axis pairs differ and its own pair
      // is alike; its distance is then below 40, so six bits carry it.
      for (int k = 0; k < NUM_CORNERS; k++) begin
         c_blend_in[k]  = !alike[0] && !alike[1] && alike[k+2];
         c_weight_in[k] = BLEND_BASE - 10'(pair_dist[k+2][5:0]) * BLEND_SLOPE;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         c_blend_ff  <= c_blend_in;
         c_weight_ff <= c_weight_in;
         c_mid_ff    <= b_mid_ff;
         c_centre_ff <= b_centre_ff;
         c_nbytes_ff <= b_nbytes_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage D: blend numerator 800e + (m - e)W + 400 per byte. With W below
   // 800 it always lies in 0 .. 800*255+400, so no clamping is needed. The
   // division by 800 starts here with the shift right by 5, a division by 32.
   // ------------------------------------------------------------------
   logic [12:0] d_part_in [NUM_CORNERS][BYTES_PER_WORD];
   logic [12:0] d_part_ff [NUM_CORNERS][BYTES_PER_WORD];
   logic [NUM_CORNERS-1:0] d_blend_ff;
   pixel_type   d_centre_ff;
   nbytes_type  d_nbytes_ff;
   logic signed [19:0] e_s;
   logic signed [19:0] m_s;
   logic signed [19:0] w_s;
   logic signed [19:0] num;

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int i = 0; i < BYTES_PER_WORD; i++) begin
            e_s = $signed({12'd0, c_centre_ff[i*BYTE_W +: BYTE_W]});
            m_s = $signed({12'd0, c_mid_ff[k][i*BYTE_W +: BYTE_W]});
            w_s = $signed({10'd0, c_weight_ff[k]});
            num = e_s * 20'sd800 + (m_s - e_s) * w_s + 20'sd400;
            d_part_in[k][i] = num[17:5];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         d_part_ff   <= d_part_in;
         d_blend_ff  <= c_blend_ff;
         d_centre_ff <= c_centre_ff;
         d_nbytes_ff <= c_nbytes_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage E (output register): finish the division by 800 as a division
   // by 25, choose blended or copied bytes, and clear bytes not in use.
   // ------------------------------------------------------------------
   pixel_type   rsp_pix_in [NUM_CORNERS];
   pixel_type   rsp_pix_ff [NUM_CORNERS];
   logic [26:0] q_prod;

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int i = 0; i < BYTES_PER_WORD; i++) begin
            q_prod = 27'(d_part_ff[k][i]) * 27'(DIV25_MUL);
            if (32'(i) >= 32'(d_nbytes_ff)) begin
               rsp_pix_in[k][i*BYTE_W +: BYTE_W] = '0;
            end else if (d_blend_ff[k]) begin
               rsp_pix_in[k][i*BYTE_W +: BYTE_W] = q_prod[DIV25_SHIFT +: BYTE_W];
            end else begin
               rsp_pix_in[k][i*BYTE_W +: BYTE_W] = d_centre_ff[i*BYTE_W +: BYTE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pix_ff <= rsp_pix_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.upper_left_out  = rsp_pix_ff[0];
   assign rsp_bus.upper_right_out = rsp_pix_ff[1];
   assign rsp_bus.lower_left_out  = rsp_pix_ff[2];
   assign rsp_bus.lower_right_out = rsp_pix_ff[3];

endmodule

FILE: src/e2x_checker.sv
// Port-level checks for the edge-directed 2x scaler and the bind that
// attaches them to it. Depends on e2x_pkg and edge_directed_2x_scaler.
module e2x_checker import e2x_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pixel_type             ul_out,
   input pixel_type             ur_out,
   input pixel_type             ll_out,
   input pixel_type             lr_out,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic [CSR_DATA_W-1:0] pwdata,
   input logic                  pready
);

   // Beats taken but not yet delivered.
   logic [2:0] inflight_ff;
   logic [2:0] inflight_in;
   // Copy of pixel_bytes as seen on the configuration port.
   logic [2:0] bytes_ff;
   pixel_type  keep_mask;

   always_comb begin
      inflight_in = inflight_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
      if (bytes_ff == 3'd0 || bytes_ff == 3'd1) begin
         keep_mask = 32'h0000_00FF;
      end else if (bytes_ff == 3'd2) begin
         keep_mask = 32'h0000_FFFF;
      end else if (bytes_ff == 3'd3) begin
         keep_mask = 32'h00FF_FFFF;
      end else begin
         keep_mask = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         bytes_ff    <= PIXEL_BYTES_RESET;
      end else begin
         inflight_ff <= inflight_in;
         if (psel && penable && pwrite && pready && paddr == REG_PIXEL_BYTES_ADDR) begin
            bytes_ff <= pwdata[2:0];
         end
      end
   end

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered straight after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 3'd0)
      else $error("result beat offered with no beat in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      32'(inflight_ff) <= PIPE_STAGES)
      else $error("more beats in flight than pipeline stages");

   a_unused_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((ul_out | ur_out | ll_out | lr_out) & ~keep_mask) == '0)
      else $error("bytes beyond pixel_bytes are not zero");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ul_out) && $stable(ur_out)
                                  && $stable(ll_out) && $stable(lr_out))
      else $error("stalled result beat changed");

endmodule

bind edge_directed_2x_scaler e2x_checker u_e2x_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .ul_out    (rsp_bus.upper_left_out),
   .ur_out    (rsp_bus.upper_right_out),
   .ll_out    (rsp_bus.lower_left_out),
   .lr_out    (rsp_bus.lower_right_out),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .pready    (pready)
);
